FILE: hw/rtl/rpt_pkg.sv
// Shared types, op codes and datapath command codes for the regroup/patch table.
// Depends on nothing; every other file of the block but rpt_ram imports it.
`default_nettype none
package rpt_pkg;

    localparam logic [3:0] OP_UPDATE = 4'd0;
    localparam logic [3:0] OP_ADDG   = 4'd1;
    localparam logic [3:0] OP_ADDU   = 4'd2;
    localparam logic [3:0] OP_REMG   = 4'd3;
    localparam logic [3:0] OP_REMU   = 4'd4;
    localparam logic [3:0] OP_CLEAR  = 4'd5;
    localparam logic [3:0] OP_SETKEY = 4'd6;
    localparam logic [3:0] OP_QGROUP = 4'd7;
    localparam logic [3:0] OP_QSUPER = 4'd8;
    localparam logic [3:0] OP_SWEEP  = 4'd9;

    localparam logic [15:0] TTL_RESET = 16'd20;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] now_seconds;
        logic [15:0] group_id;
        logic [31:0] member_id;
        logic        patch_flag;
        logic        active_flag;
        logic [15:0] key_value;
        logic        key_present;
        logic [7:0]  alg_value;
        logic        alg_present;
        logic [4:0]  ssn_value;
        logic        ssn_present;
    } t_in;

    typedef struct packed {
        logic       key_clear;
        logic [3:0] entry_count;
    } t_out;

    typedef enum logic [4:0] {
        C_NOP, C_LOAD, C_LOC_STEP, C_CREATE, C_UPD, C_MRD, C_MCMP, C_APPEND,
        C_RDLAST, C_MOVE, C_DEACT, C_CLEAR, C_SETKEY, C_QSUP, C_GQ_ENT, C_NEXT,
        C_SWP_STEP, C_SWP_END, C_DONE
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       skip;
        logic       found;
        logic       i_last;
        logic       i_in;
        logic       k_end;
        logic       hit;
        logic       elig;
    } t_status;

    function automatic logic f_stale(input logic [31:0] ls, input logic [31:0] now,
                                     input logic [15:0] ttl);
        logic [31:0] age;
        age = now - ls;
        return (ls != 32'd0) && (now > ls) && (age > {16'd0, ttl});
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/regroup_patch_table.sv
// Top level of the regroup/patch supergroup table: sequencer plus datapath.
// Depends on rpt_pkg, rpt_ctrl, rpt_dp (and rpt_ram through rpt_dp).
//
//  channel   handshake                  word
//  request   start / busy               i_req   (t_in)
//  result    o_done (one-cycle strobe)  o_res   (t_out)
//  config    i_cfg_valid / o_cfg_ready  i_cfg_data (ttl_seconds)
//
// One op at a time. Locating a supergroup scans all ENTRIES rows, one per cycle;
// member work reads each member compared from the RAM (registered read) and then
// compares it. The result strobe comes in the first cycle with busy low and
// cannot be held off by the receiver.
// Synchronous active-low reset; no clearing pass needed.
`default_nettype none
module regroup_patch_table #(
    parameter int ENTRIES = 8,
    parameter int MEMBERS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rpt_pkg::t_in  i_req,
    output logic               o_done,
    output rpt_pkg::t_out      o_res,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [15:0]   i_cfg_data
);
    import rpt_pkg::*;

    t_cmd    cmd;
    t_status status;

    rpt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rpt_dp #(.ENTRIES(ENTRIES), .MEMBERS(MEMBERS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_req),
        .o_status    (status),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/rpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/rpt_ctrl.sv
// Sequencer for the regroup/patch table: walks each op through datapath commands.
// Depends on rpt_pkg.
`default_nettype none
module rpt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire rpt_pkg::t_status i_status,
    output rpt_pkg::t_cmd         o_cmd
);
    import rpt_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_DISP   = 15'h0002,
        S_LOC    = 15'h0004,
        S_ALOC   = 15'h0008,
        S_KEY    = 15'h0010,
        S_MRD    = 15'h0020,
        S_MCMP   = 15'h0040,
        S_RDLAST = 15'h0080,
        S_MOVE   = 15'h0100,
        S_DEACT  = 15'h0200,
        S_GQENT  = 15'h0400,
        S_GQCHK  = 15'h0800,
        S_GQNXT  = 15'h1000,
        S_SWP    = 15'h2000,
        S_DONE   = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic   rem_op;

    assign rem_op = (i_status.op == OP_REMG) || (i_status.op == OP_REMU);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = C_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_status.skip) begin
                    n_state = S_DONE;
                end else if (i_status.op == OP_QGROUP) begin
                    n_state = S_GQENT;
                end else if (i_status.op == OP_SWEEP) begin
                    n_state = S_SWP;
                end else begin
                    n_state = S_LOC;
                end
            end
            S_LOC: begin
                o_cmd = C_LOC_STEP;
                if (i_status.i_last) begin
                    n_state = S_ALOC;
                end
            end
            S_ALOC: begin
                n_state = S_DONE;
                case (i_status.op)
                    OP_UPDATE: o_cmd = i_status.found ? C_UPD : C_CREATE;
                    OP_ADDG, OP_ADDU: begin
                        o_cmd   = i_status.found ? C_NOP : C_CREATE;
                        n_state = S_MRD;
                    end
                    OP_SETKEY: begin
                        o_cmd   = i_status.found ? C_NOP : C_CREATE;
                        n_state = S_KEY;
                    end
                    OP_REMG, OP_REMU: begin
                        if (i_status.found) begin
                            n_state = S_MRD;
                        end
                    end
                    OP_CLEAR:  o_cmd = i_status.found ? C_CLEAR : C_NOP;
                    OP_QSUPER: o_cmd = i_status.found ? C_QSUP : C_NOP;
                    default:   o_cmd = C_NOP;
                endcase
            end
            S_KEY: begin
                o_cmd   = C_SETKEY;
                n_state = S_DONE;
            end
            S_MRD: begin
                if (i_status.k_end) begin
                    if (i_status.op == OP_ADDG || i_status.op == OP_ADDU) begin
                        o_cmd   = C_APPEND;
                        n_state = S_DONE;
                    end else if (rem_op) begin
                        n_state = S_DEACT;
                    end else begin
                        n_state = S_GQNXT;
                    end
                end else begin
                    o_cmd   = C_MRD;
                    n_state = S_MCMP;
                end
            end
            S_MCMP: begin
                o_cmd = C_MCMP;
                if (i_status.hit) begin
                    n_state = rem_op ? S_RDLAST : S_DONE;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_RDLAST: begin
                o_cmd   = C_RDLAST;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                o_cmd   = C_MOVE;
                n_state = S_DEACT;
            end
            S_DEACT: begin
                o_cmd   = C_DEACT;
                n_state = S_DONE;
            end
            S_GQENT: begin
                if (i_status.i_in) begin
                    o_cmd   = C_GQ_ENT;
                    n_state = S_GQCHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_GQCHK: n_state = i_status.elig ? S_MRD : S_GQNXT;
            S_GQNXT: begin
                o_cmd   = C_NEXT;
                n_state = S_GQENT;
            end
            S_SWP: begin
                if (i_status.i_in) begin
                    o_cmd = C_SWP_STEP;
                end else begin
                    o_cmd   = C_SWP_END;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd   = C_DONE;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/rpt_dp.sv
// Datapath of the regroup/patch table: entry registers, member RAMs, scan counters.
// Depends on rpt_pkg and rpt_ram.
`default_nettype none
module rpt_dp #(
    parameter int ENTRIES = 8,
    parameter int MEMBERS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rpt_pkg::t_cmd    i_cmd,
    input  wire rpt_pkg::t_in     i_in,
    output rpt_pkg::t_status      o_status,
    output logic                  o_done,
    output rpt_pkg::t_out         o_res,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [15:0]      i_cfg_data
);
    import rpt_pkg::*;

    localparam int IW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int MW    = $clog2(MEMBERS);
    localparam int NW    = $clog2(MEMBERS + 1);
    localparam int AW    = IW + MW;
    localparam int DEPTH = ENTRIES << MW;

    t_in          r_req;
    logic [15:0]  r_ttl;
    logic [CW-1:0] r_used, r_i, r_w;
    logic [IW-1:0] r_e, r_minidx;
    logic [NW-1:0] r_k;
    logic [31:0]  r_minls;
    logic         r_found, r_elig, r_ans;

    logic [15:0]   r_sg    [ENTRIES];
    logic          r_patch [ENTRIES];
    logic          r_act   [ENTRIES];
    logic [31:0]   r_ls    [ENTRIES];
    logic [NW-1:0] r_gcnt  [ENTRIES];
    logic [NW-1:0] r_ucnt  [ENTRIES];
    logic [15:0]   r_key   [ENTRIES];
    logic          r_kk    [ENTRIES];
    logic [7:0]    r_alg   [ENTRIES];
    logic [4:0]    r_ssn   [ENTRIES];
    logic [IW-1:0] r_slot  [ENTRIES];

    logic [IW-1:0] ii, wi, tgt;
    logic          unit_sel, hit, key_zero, stale_e;
    logic [15:0]   mg;
    logic [NW-1:0] cnt_sel, mem_k;
    logic [AW-1:0] maddr;
    logic          mwe;
    logic [15:0]   g_rdata;
    logic [31:0]   u_rdata;
    logic [CW+3:0] used_ext;

    assign ii       = r_i[IW-1:0];
    assign wi       = r_w[IW-1:0];
    assign mg       = r_req.member_id[15:0];
    assign unit_sel = (r_req.op == OP_ADDU) || (r_req.op == OP_REMU);
    assign cnt_sel  = unit_sel ? r_ucnt[r_e] : r_gcnt[r_e];
    assign hit      = unit_sel ? (u_rdata == r_req.member_id) : (g_rdata == mg);
    assign key_zero = r_kk[r_e] && (r_key[r_e] == 16'd0);
    assign stale_e  = f_stale(r_ls[r_e], r_req.now_seconds, r_ttl);
    assign tgt      = (r_used < CW'(ENTRIES)) ? r_used[IW-1:0] : r_minidx;

    always_comb begin
        mem_k = r_k;
        if (i_cmd == C_RDLAST) begin
            mem_k = cnt_sel - NW'(1);
        end else if (i_cmd == C_APPEND) begin
            mem_k = cnt_sel;
        end
    end
    assign maddr = {r_slot[r_e], mem_k[MW-1:0]};
    assign mwe   = ((i_cmd == C_APPEND) && (cnt_sel < NW'(MEMBERS))) || (i_cmd == C_MOVE);

    rpt_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_gram (
        .i_clk   (i_clk),
        .i_we    (mwe && !unit_sel),
        .i_waddr (maddr),
        .i_wdata ((i_cmd == C_APPEND) ? mg : g_rdata),
        .i_raddr (maddr),
        .o_rdata (g_rdata)
    );

    rpt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_uram (
        .i_clk   (i_clk),
        .i_we    (mwe && unit_sel),
        .i_waddr (maddr),
        .i_wdata ((i_cmd == C_APPEND) ? r_req.member_id : u_rdata),
        .i_raddr (maddr),
        .o_rdata (u_rdata)
    );

    always_comb begin
        o_status.op     = r_req.op;
        o_status.found  = r_found;
        o_status.i_last = (r_i == CW'(ENTRIES - 1));
        o_status.i_in   = (r_i < r_used);
        o_status.k_end  = (r_k >= cnt_sel);
        o_status.hit    = hit;
        o_status.elig   = r_elig;
        if (r_req.op == OP_QGROUP) begin
            o_status.skip = (mg == 16'd0);
        end else if (r_req.op == OP_SWEEP) begin
            o_status.skip = 1'b0;
        end else begin
            o_status.skip = (r_req.op > OP_QSUPER) || (r_req.group_id == 16'd0)
                || ((r_req.op == OP_ADDG || r_req.op == OP_REMG) && mg == 16'd0)
                || ((r_req.op == OP_ADDU || r_req.op == OP_REMU)
                    && r_req.member_id == 32'd0);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign used_ext    = {4'd0, r_used};

    // request word and result
    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LOAD) begin
            r_req <= i_in;
        end
        if (i_cmd == C_DONE) begin
            o_res.key_clear   <= r_ans;
            o_res.entry_count <= used_ext[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl    <= TTL_RESET;
            r_used   <= '0;
            r_i      <= '0;
            r_w      <= '0;
            r_e      <= '0;
            r_k      <= '0;
            r_minidx <= '0;
            r_minls  <= '0;
            r_found  <= 1'b0;
            r_elig   <= 1'b0;
            r_ans    <= 1'b0;
            o_done   <= 1'b0;
            for (int j = 0; j < ENTRIES; j++) begin
                r_patch[j] <= 1'b0;
                r_act[j]   <= 1'b0;
                r_ls[j]    <= '0;
                r_gcnt[j]  <= '0;
                r_ucnt[j]  <= '0;
                r_key[j]   <= '0;
                r_kk[j]    <= 1'b0;
                r_alg[j]   <= '0;
                r_ssn[j]   <= '0;
                r_slot[j]  <= IW'(j);
            end
        end else begin
            o_done <= (i_cmd == C_DONE);
            if (i_cfg_valid) begin
                r_ttl <= i_cfg_data;
            end
            case (i_cmd)
                C_LOAD: begin
                    r_i     <= '0;
                    r_w     <= '0;
                    r_k     <= '0;
                    r_found <= 1'b0;
                    r_ans   <= 1'b0;
                end
                C_LOC_STEP: begin
                    if ((r_i < r_used) && (r_sg[ii] == r_req.group_id) && !r_found) begin
                        r_found <= 1'b1;
                        r_e     <= ii;
                    end
                    // first smallest last-seen, for replacement when full
                    if (r_i == '0 || r_ls[ii] < r_minls) begin
                        r_minidx <= ii;
                        r_minls  <= r_ls[ii];
                    end
                    r_i <= r_i + CW'(1);
                end
                C_CREATE: begin
                    if (r_used < CW'(ENTRIES)) begin
                        r_used <= r_used + CW'(1);
                    end
                    r_e          <= tgt;
                    r_sg[tgt]    <= r_req.group_id;
                    r_patch[tgt] <= (r_req.op == OP_UPDATE) ? r_req.patch_flag : 1'b1;
                    r_act[tgt]   <= (r_req.op == OP_UPDATE) ? r_req.active_flag : 1'b1;
                    r_ls[tgt]    <= r_req.now_seconds;
                    r_gcnt[tgt]  <= '0;
                    r_ucnt[tgt]  <= '0;
                    r_kk[tgt]    <= 1'b0;
                    r_k          <= '0;
                end
                C_UPD: begin
                    r_patch[r_e] <= r_req.patch_flag;
                    r_act[r_e]   <= r_req.active_flag;
                    r_ls[r_e]    <= r_req.now_seconds;
                end
                C_MCMP: begin
                    if (hit) begin
                        if (r_req.op == OP_QGROUP) begin
                            r_ans <= key_zero;
                        end
                    end else begin
                        r_k <= r_k + NW'(1);
                    end
                end
                C_APPEND: begin
                    if (cnt_sel < NW'(MEMBERS)) begin
                        if (unit_sel) begin
                            r_ucnt[r_e] <= cnt_sel + NW'(1);
                        end else begin
                            r_gcnt[r_e] <= cnt_sel + NW'(1);
                        end
                    end
                end
                C_MOVE: begin
                    if (unit_sel) begin
                        r_ucnt[r_e] <= cnt_sel - NW'(1);
                    end else begin
                        r_gcnt[r_e] <= cnt_sel - NW'(1);
                    end
                end
                C_DEACT: begin
                    if (r_gcnt[r_e] == '0 && r_ucnt[r_e] == '0) begin
                        r_act[r_e] <= 1'b0;
                    end
                end
                C_CLEAR: begin
                    r_gcnt[r_e] <= '0;
                    r_ucnt[r_e] <= '0;
                    r_act[r_e]  <= 1'b0;
                end
                C_SETKEY: begin
                    if (r_req.key_present) begin
                        r_key[r_e] <= r_req.key_value;
                        r_kk[r_e]  <= 1'b1;
                    end
                    if (r_req.alg_present) begin
                        r_alg[r_e] <= r_req.alg_value;
                    end
                    if (r_req.ssn_present) begin
                        r_ssn[r_e] <= r_req.ssn_value;
                    end
                end
                C_QSUP: r_ans <= r_act[r_e] && !stale_e && key_zero;
                C_GQ_ENT: begin
                    r_e    <= ii;
                    r_k    <= '0;
                    r_elig <= r_act[ii] && !f_stale(r_ls[ii], r_req.now_seconds, r_ttl);
                end
                C_NEXT: r_i <= r_i + CW'(1);
                C_SWP_STEP: begin
                    // keep fresh entries in order; swap the stale ones (and their
                    // member slots) toward the tail
                    if (!f_stale(r_ls[ii], r_req.now_seconds, r_ttl)) begin
                        if (r_w != r_i) begin
                            r_sg[wi]    <= r_sg[ii];    r_sg[ii]    <= r_sg[wi];
                            r_patch[wi] <= r_patch[ii]; r_patch[ii] <= r_patch[wi];
                            r_act[wi]   <= r_act[ii];   r_act[ii]   <= r_act[wi];
                            r_ls[wi]    <= r_ls[ii];    r_ls[ii]    <= r_ls[wi];
                            r_gcnt[wi]  <= r_gcnt[ii];  r_gcnt[ii]  <= r_gcnt[wi];
                            r_ucnt[wi]  <= r_ucnt[ii];  r_ucnt[ii]  <= r_ucnt[wi];
                            r_key[wi]   <= r_key[ii];   r_key[ii]   <= r_key[wi];
                            r_kk[wi]    <= r_kk[ii];    r_kk[ii]    <= r_kk[wi];
                            r_alg[wi]   <= r_alg[ii];   r_alg[ii]   <= r_alg[wi];
                            r_ssn[wi]   <= r_ssn[ii];   r_ssn[ii]   <= r_ssn[wi];
                            r_slot[wi]  <= r_slot[ii];  r_slot[ii]  <= r_slot[wi];
                        end
                        r_w <= r_w + CW'(1);
                    end
                    r_i <= r_i + CW'(1);
                end
                C_SWP_END: r_used <= r_w;
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire
